// ===== rtl/bcsc_pkg.sv =====
package bcsc_pkg;

    localparam int COUNT_BITS = 16;

    localparam int MV_W    = 16;
    localparam int MA_W    = 16;
    localparam int TAPER_W = 15;
    localparam int HOLD_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RECHARGE_MV_FAST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECHARGE_MV_NORMAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV_FAST       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV_NORMAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER_CURRENT_MA   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES       = 3'd5;

    localparam logic [MV_W-1:0]    RECHARGE_MV_FAST_RST   = 16'd7900;
    localparam logic [MV_W-1:0]    RECHARGE_MV_NORMAL_RST = 16'd8100;
    localparam logic [MV_W-1:0]    FULL_MV_FAST_RST       = 16'd8150;
    localparam logic [MV_W-1:0]    FULL_MV_NORMAL_RST     = 16'd8350;
    localparam logic [TAPER_W-1:0] TAPER_CURRENT_MA_RST   = 15'd500;
    localparam logic [HOLD_W-1:0]  HOLD_SAMPLES_RST       = 16'd50;

    typedef enum logic [1:0] {
        ST_NOT_CONNECTED = 2'd0,
        ST_INACTIVE      = 2'd1,
        ST_ACTIVE        = 2'd2
    } charger_state_t;

endpackage

// ===== rtl/bcsc_sample_if.sv =====
interface bcsc_sample_if
    import bcsc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [MV_W-1:0]        battery_mv;
    logic signed [MA_W-1:0] battery_ma;
    logic                   temp_ok;
    logic                   mains_present;
    logic                   fast_mode;

    modport source (
        output valid, battery_mv, battery_ma, temp_ok, mains_present, fast_mode,
        input  ready
    );
    modport sink (
        input  valid, battery_mv, battery_ma, temp_ok, mains_present, fast_mode,
        output ready
    );
endinterface

// ===== rtl/bcsc_result_if.sv =====
interface bcsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] charger_state;
    logic       state_changed;
    logic       charger_enable;
    logic       enable_fast;
    logic       full_charge_event;

    modport source (
        output valid, charger_state, state_changed, charger_enable, enable_fast,
               full_charge_event,
        input  ready
    );
    modport sink (
        input  valid, charger_state, state_changed, charger_enable, enable_fast,
               full_charge_event,
        output ready
    );
endinterface

// ===== rtl/bcsc_cfg_if.sv =====
interface bcsc_cfg_if
    import bcsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/battery_charge_state_controller.sv =====
// A request is registered on acceptance; its result is registered in the output register when
// the held request advances, which waits while a pending result is not taken.
// Throughput: one request per cycle unless a result waits on result.ready.
// Reset (rst_n low, asynchronous): state not connected, counters zero, registers at
// their default thresholds, no request held and no result pending.
module battery_charge_state_controller
    import bcsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bcsc_sample_if.sink          sample,
    bcsc_result_if.source        result,
    bcsc_cfg_if.sink             cfg
);

    localparam int WIDE_W = 33;
    localparam logic [WIDE_W-1:0] CMAX_WIDE = WIDE_W'({COUNT_BITS{1'b1}});

    logic [MV_W-1:0]    recharge_mv_fast_reg;
    logic [MV_W-1:0]    recharge_mv_normal_reg;
    logic [MV_W-1:0]    full_mv_fast_reg;
    logic [MV_W-1:0]    full_mv_normal_reg;
    logic [TAPER_W-1:0] taper_current_ma_reg;
    logic [HOLD_W-1:0]  hold_samples_reg;

    logic                   s1_valid_reg;
    logic [MV_W-1:0]        mv_reg;
    logic signed [MA_W-1:0] ma_reg;
    logic                   temp_ok_reg;
    logic                   mains_reg;
    logic                   fast_reg;

    charger_state_t         state_reg, state_next;
    logic [COUNT_BITS-1:0]  lvf_count_reg, lvf_count_next;
    logic [COUNT_BITS-1:0]  lvn_count_reg, lvn_count_next;
    logic [COUNT_BITS-1:0]  lc_count_reg, lc_count_next;

    logic       out_valid_reg;
    logic [1:0] out_state_reg;
    logic       out_changed_reg;
    logic       out_enable_reg;
    logic       out_en_fast_reg;
    logic       out_full_reg;

    logic                  s1_advance;
    logic [WIDE_W-1:0]     hold_wide;
    logic [COUNT_BITS-1:0] limit;
    logic                  full_event;
    logic                  enable;
    logic                  changed;
    logic [COUNT_BITS-1:0] lc_base;
    logic [COUNT_BITS-1:0] stepped;
    logic                  qualify;
    logic                  low_current;
    logic [MV_W-1:0]       full_mv;

    function automatic logic [COUNT_BITS:0] count_step(
        input logic [COUNT_BITS-1:0] cnt,
        input logic                  cond,
        input logic [COUNT_BITS-1:0] lim
    );
        logic [COUNT_BITS-1:0] nxt;
        nxt = cnt;
        if (!cond)
        begin
            return {1'b0, {COUNT_BITS{1'b0}}};
        end
        if (cnt < lim)
        begin
            nxt = cnt + 1'b1;
        end
        return {(nxt >= lim), nxt};
    endfunction

    assign cfg.ready    = 1'b1;
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_advance;

    assign hold_wide = WIDE_W'(hold_samples_reg);
    assign limit     = (hold_wide > CMAX_WIDE) ? CMAX_WIDE[COUNT_BITS-1:0]
                                               : hold_wide[COUNT_BITS-1:0];

    assign low_current = ma_reg < $signed({1'b0, taper_current_ma_reg});
    assign full_mv     = fast_reg ? full_mv_fast_reg : full_mv_normal_reg;

    always_comb
    begin
        state_next     = state_reg;
        lvf_count_next = lvf_count_reg;
        lvn_count_next = lvn_count_reg;
        lc_count_next  = lc_count_reg;
        full_event     = 1'b0;
        lc_base        = lc_count_reg;
        stepped        = '0;
        qualify        = 1'b0;
        case (state_reg)
            ST_NOT_CONNECTED:
            begin
                if (mains_reg && temp_ok_reg)
                begin
                    state_next     = ST_INACTIVE;
                    lvf_count_next = '0;
                    lvn_count_next = '0;
                    lc_count_next  = '0;
                end
            end
            ST_INACTIVE:
            begin
                if (!mains_reg)
                begin
                    state_next = ST_NOT_CONNECTED;
                end
                else if (temp_ok_reg)
                begin
                    if (fast_reg)
                    begin
                        {qualify, stepped} = count_step(lvf_count_reg,
                                                        mv_reg < recharge_mv_fast_reg, limit);
                        lvf_count_next = stepped;
                    end
                    else
                    begin
                        {qualify, stepped} = count_step(lvn_count_reg,
                                                        mv_reg < recharge_mv_normal_reg, limit);
                        lvn_count_next = stepped;
                    end
                    if (qualify)
                    begin
                        state_next = ST_ACTIVE;
                    end
                end
            end
            ST_ACTIVE:
            begin
                if (!mains_reg)
                begin
                    state_next = ST_NOT_CONNECTED;
                end
                else
                begin
                    if (!temp_ok_reg)
                    begin
                        state_next     = ST_INACTIVE;
                        lvf_count_next = '0;
                        lvn_count_next = '0;
                        lc_base        = '0;
                    end
                    {qualify, stepped} = count_step(lc_base, low_current, limit);
                    lc_count_next = stepped;
                    if (qualify && (mv_reg >= full_mv))
                    begin
                        state_next     = ST_INACTIVE;
                        lvf_count_next = '0;
                        lvn_count_next = '0;
                        lc_count_next  = '0;
                        full_event     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_NOT_CONNECTED;
            end
        endcase
    end

    assign changed = state_next != state_reg;
    assign enable  = state_next != ST_INACTIVE;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recharge_mv_fast_reg   <= RECHARGE_MV_FAST_RST;
            recharge_mv_normal_reg <= RECHARGE_MV_NORMAL_RST;
            full_mv_fast_reg       <= FULL_MV_FAST_RST;
            full_mv_normal_reg     <= FULL_MV_NORMAL_RST;
            taper_current_ma_reg   <= TAPER_CURRENT_MA_RST;
            hold_samples_reg       <= HOLD_SAMPLES_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RECHARGE_MV_FAST:   recharge_mv_fast_reg   <= cfg.data;
                REG_RECHARGE_MV_NORMAL: recharge_mv_normal_reg <= cfg.data;
                REG_FULL_MV_FAST:       full_mv_fast_reg       <= cfg.data;
                REG_FULL_MV_NORMAL:     full_mv_normal_reg     <= cfg.data;
                REG_TAPER_CURRENT_MA:   taper_current_ma_reg   <= cfg.data[TAPER_W-1:0];
                REG_HOLD_SAMPLES:       hold_samples_reg       <= cfg.data;
                default:                ;
            endcase
        end
    end

    // hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            mv_reg      <= sample.battery_mv;
            ma_reg      <= sample.battery_ma;
            temp_ok_reg <= sample.temp_ok;
            mains_reg   <= sample.mains_present;
            fast_reg    <= sample.fast_mode;
        end
    end

    // advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NOT_CONNECTED;
            lvf_count_reg <= '0;
            lvn_count_reg <= '0;
            lc_count_reg  <= '0;
        end
        else if (s1_advance)
        begin
            state_reg     <= state_next;
            lvf_count_reg <= lvf_count_next;
            lvn_count_reg <= lvn_count_next;
            lc_count_reg  <= lc_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_state_reg   <= 2'(state_next);
            out_changed_reg <= changed;
            out_enable_reg  <= enable;
            out_en_fast_reg <= changed && enable && fast_reg;
            out_full_reg    <= full_event;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.charger_state     = out_state_reg;
    assign result.state_changed     = out_changed_reg;
    assign result.charger_enable    = out_enable_reg;
    assign result.enable_fast       = out_en_fast_reg;
    assign result.full_charge_event = out_full_reg;

endmodule
